FILE: src/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg
// Shared types and codes of the C escape sequence decoder.
// ----------------------------------------------------------------------------
package cesd_pkg;

	typedef enum logic [2:0] {
		EV_PLAIN  = 3'd0,
		EV_MORE   = 3'd1,
		EV_DONE   = 3'd2,
		EV_END    = 3'd3,
		EV_REPUSH = 3'd4
	} cesd_event_t;

	typedef struct packed {
		logic [31:0] value_acc;
		logic [3:0]  hex_left;
		logic [1:0]  oct_left;
		logic        in_hex_run;
		logic        after_slash;
	} cesd_state_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h5c;
	localparam logic [3:0] UCHERS_SHORT = 4'd4;
	localparam logic [3:0] UCHERS_LONG  = 4'd8;
	localparam logic [1:0] OCT_MORE     = 2'd2;

endpackage

FILE: src/cesd_decode.sv
// ----------------------------------------------------------------------------
// cesd_decode
// Next-state and event logic for one source byte.
// ----------------------------------------------------------------------------
module cesd_decode (
	input  cesd_pkg::cesd_state_t cur,
	input  logic [7:0]            in_byte,
	output cesd_pkg::cesd_state_t nxt,
	output cesd_pkg::cesd_event_t ev
);

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	// map through the symmetric pair table; unknown bytes map to themselves
	function automatic logic [7:0] pair_of(input logic [7:0] c);
		logic [7:0] p;
		unique case (c)
			8'h61: p = 8'h07;
			8'h07: p = 8'h61;
			8'h62: p = 8'h08;
			8'h08: p = 8'h62;
			8'h66: p = 8'h0c;
			8'h0c: p = 8'h66;
			8'h6e: p = 8'h0a;
			8'h0a: p = 8'h6e;
			8'h72: p = 8'h0d;
			8'h0d: p = 8'h72;
			8'h74: p = 8'h09;
			8'h09: p = 8'h74;
			8'h76: p = 8'h0b;
			8'h0b: p = 8'h76;
			default: p = c;
		endcase
		return p;
	endfunction

	logic [5:0]  hex_sh;
	logic [3:0]  oct_sh;
	logic [31:0] hex_pad;
	logic [31:0] oct_pad;

	assign hex_sh  = {cur.hex_left, 2'b00};
	assign oct_sh  = {1'b0, cur.oct_left, 1'b0} + {2'b00, cur.oct_left};
	assign hex_pad = hex_sh[5] ? 32'd0 : (cur.value_acc << hex_sh[4:0]);
	assign oct_pad = cur.value_acc << oct_sh;

	always_comb begin
		nxt = cur;
		ev  = cesd_pkg::EV_PLAIN;
		priority if (in_byte == cesd_pkg::CH_NUL) begin
			priority if (cur.hex_left != 4'd0) begin
				nxt.value_acc = hex_pad;
			end else if (cur.oct_left != 2'd0) begin
				nxt.value_acc = oct_pad;
			end else if (cur.in_hex_run) begin
				nxt.value_acc = cur.value_acc;
			end else if (cur.after_slash) begin
				nxt.value_acc = {24'd0, cesd_pkg::CH_SLASH};
			end else begin
				nxt.value_acc = 32'd0;
			end
			nxt.hex_left    = 4'd0;
			nxt.oct_left    = 2'd0;
			nxt.in_hex_run  = 1'b0;
			nxt.after_slash = 1'b0;
			ev = cesd_pkg::EV_END;
		end else if (cur.hex_left != 4'd0) begin
			nxt.value_acc = {cur.value_acc[27:0], hex_val(in_byte)};
			nxt.hex_left  = cur.hex_left - 4'd1;
			ev = (cur.hex_left == 4'd1) ? cesd_pkg::EV_DONE : cesd_pkg::EV_MORE;
		end else if (cur.oct_left != 2'd0) begin
			nxt.value_acc = {cur.value_acc[28:0], in_byte[2:0]};
			nxt.oct_left  = cur.oct_left - 2'd1;
			ev = (cur.oct_left == 2'd1) ? cesd_pkg::EV_DONE : cesd_pkg::EV_MORE;
		end else if (cur.in_hex_run) begin
			priority if (is_hex(in_byte)) begin
				nxt.value_acc = {cur.value_acc[27:0], hex_val(in_byte)};
				ev = cesd_pkg::EV_MORE;
			end else if (in_byte == cesd_pkg::CH_SLASH) begin
				nxt.in_hex_run  = 1'b0;
				nxt.after_slash = 1'b1;
				ev = cesd_pkg::EV_DONE;
			end else begin
				nxt.in_hex_run = 1'b0;
				ev = cesd_pkg::EV_REPUSH;
			end
		end else if (cur.after_slash) begin
			nxt.after_slash = 1'b0;
			priority if (in_byte == 8'h75) begin
				nxt.value_acc = 32'd0;
				nxt.hex_left  = cesd_pkg::UCHERS_SHORT;
				ev = cesd_pkg::EV_MORE;
			end else if (in_byte == 8'h55) begin
				nxt.value_acc = 32'd0;
				nxt.hex_left  = cesd_pkg::UCHERS_LONG;
				ev = cesd_pkg::EV_MORE;
			end else if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
				nxt.value_acc = {29'd0, in_byte[2:0]};
				nxt.oct_left  = cesd_pkg::OCT_MORE;
				ev = cesd_pkg::EV_MORE;
			end else if (in_byte == 8'h78) begin
				nxt.value_acc  = 32'd0;
				nxt.in_hex_run = 1'b1;
				ev = cesd_pkg::EV_MORE;
			end else begin
				nxt.value_acc = {24'd0, pair_of(in_byte)};
				ev = cesd_pkg::EV_PLAIN;
			end
		end else if (in_byte == cesd_pkg::CH_SLASH) begin
			nxt.after_slash = 1'b1;
			ev = cesd_pkg::EV_MORE;
		end else begin
			nxt.value_acc = {24'd0, in_byte};
			ev = cesd_pkg::EV_PLAIN;
		end
	end

endmodule

FILE: src/c_escape_sequence_decoder_unit.sv
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_unit
// Byte-stream C escape decoder with valid/ready channels.
// ----------------------------------------------------------------------------
// One byte is taken per clock unless the input stage is full behind a stalled
// result. Each byte gives one result (event, value): a byte register feeds the
// decode logic, whose result and new sequence state are registered together.
// The rate is one byte per cycle while out_ready is high, set by the loop from
// the sequence state registers through the decode logic back to themselves.
// A waiting result holds while one more byte enters the input stage.
module c_escape_sequence_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [31:0] code_value
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  valid_s2;
	cesd_pkg::cesd_event_t event_s2;
	logic [31:0]           value_s2;
	cesd_pkg::cesd_state_t state_q;
	cesd_pkg::cesd_state_t state_nxt;
	cesd_pkg::cesd_event_t ev_nxt;
	logic                  adv_s1;

	cesd_decode u_decode (
		.cur     (state_q),
		.in_byte (byte_s1),
		.nxt     (state_nxt),
		.ev      (ev_nxt)
	);

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
		if (adv_s1) begin
			event_s2 <= ev_nxt;
			value_s2 <= state_nxt.value_acc;
		end
	end

	assign out_valid  = valid_s2;
	assign event_res  = event_s2;
	assign code_value = value_s2;

endmodule

FILE: src/cesd_checker.sv
// ----------------------------------------------------------------------------
// cesd_checker
// Port-level checks of the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cesd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_res,
	input logic [31:0] code_value
);

	logic [1:0] pending_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// track transfers in minus transfers out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown without a pending byte");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more bytes held than stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd0 |-> in_ready)
		else $error("empty block refuses input");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(code_value))
		else $error("stalled result changed");

endmodule

bind c_escape_sequence_decoder_unit cesd_checker u_cesd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_res  (event_res),
	.code_value (code_value)
);
